FILE: hw/rtl/pgm_pkg.sv
// Shared types, widths and constants of the Prewitt gradient magnitude unit.
package pgm_pkg;

    localparam int MAX_COLS_DEF = 512;
    localparam int MAX_ROWS_DEF = 512;

    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int PIX_W     = 8;
    localparam int MAG_W     = 8;
    localparam int POS_W     = 9;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;

    // Gradient sums span -765..765, their squares stay below 2**20.
    localparam int GRAD_W = 11;
    localparam int SQ_W   = 20;
    localparam int EN_W   = 21;

    localparam logic [CFG_W-1:0] SIZE_RESET = 10'd512;
    localparam logic [CFG_W-1:0] SIZE_MIN   = 10'd3;
    localparam logic [MAG_W-1:0] MAG_MAX    = 8'd255;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'b1;

    typedef struct packed {
        logic accept;
        logic win_load;
        logic grad_load;
        logic sq_load;
        logic sum_load;
        logic sqrt_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic interior;
        logic sqrt_last;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: hw/rtl/pgm_ctrl.sv
// Sequencer that steps one pixel at a time through the datapath.
module pgm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  pgm_pkg::t_dp_sts i_sts,
    output pgm_pkg::t_dp_cmd o_cmd
);
    import pgm_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_GRAD = 7'b0000100,
        S_SQ   = 7'b0001000,
        S_SUM  = 7'b0010000,
        S_SQRT = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = i_sts.interior ? S_GRAD : S_IDLE;
            end
            S_GRAD: n_state = S_SQ;
            S_SQ:   n_state = S_SUM;
            S_SUM:  n_state = S_SQRT;
            S_SQRT: begin
                if (i_sts.sqrt_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd           = '0;
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.win_load  = (r_state == S_READ);
        o_cmd.grad_load = (r_state == S_GRAD);
        o_cmd.sq_load   = (r_state == S_SQ);
        o_cmd.sum_load  = (r_state == S_SUM);
        o_cmd.sqrt_step = (r_state == S_SQRT);
        o_cmd.out_load  = (r_state == S_DONE) && i_sts.out_free;
    end

endmodule

FILE: hw/rtl/pgm_dp.sv
// Datapath: size registers, position counters, line stores, window, gradients and square root.
module pgm_dp #(
    parameter int MAX_COLS = pgm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = pgm_pkg::MAX_ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pgm_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pgm_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic [pgm_pkg::PIX_W-1:0]        i_pixel,
    input  logic                             i_frame_start,
    input  pgm_pkg::t_dp_cmd                 i_cmd,
    output pgm_pkg::t_dp_sts                 o_sts,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [pgm_pkg::MAG_W-1:0]        o_magnitude,
    output logic [pgm_pkg::POS_W-1:0]        o_out_row,
    output logic [pgm_pkg::POS_W-1:0]        o_out_col,
    output logic                             o_frame_last
);
    import pgm_pkg::*;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int NCOL_W = $clog2(MAX_COLS + 1);
    localparam int NROW_W = $clog2(MAX_ROWS + 1);

    // Size registers and their clamped values.
    logic [CFG_W-1:0]  r_image_cols;
    logic [CFG_W-1:0]  r_image_rows;
    logic [NCOL_W-1:0] eff_cols;
    logic [NROW_W-1:0] eff_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_cols <= SIZE_RESET;
            r_image_rows <= SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_COLS: r_image_cols <= i_cfg_data;
                CFG_IMAGE_ROWS: r_image_rows <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_image_cols < SIZE_MIN) begin
            eff_cols = NCOL_W'(3);
        end else if (32'(r_image_cols) > 32'(MAX_COLS)) begin
            eff_cols = NCOL_W'(MAX_COLS);
        end else begin
            eff_cols = NCOL_W'(r_image_cols);
        end
        if (r_image_rows < SIZE_MIN) begin
            eff_rows = NROW_W'(3);
        end else if (32'(r_image_rows) > 32'(MAX_ROWS)) begin
            eff_rows = NROW_W'(MAX_ROWS);
        end else begin
            eff_rows = NROW_W'(r_image_rows);
        end
    end

    // Position of the next pixel; frame_start forces row 0, column 0.
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  cur_r;
    logic [COL_W-1:0]  cur_c;
    logic [NCOL_W-1:0] c_inc;
    logic [NROW_W-1:0] r_inc;
    logic              cur_interior;
    logic              cur_last;

    always_comb begin
        cur_r = i_frame_start ? '0 : r_row;
        cur_c = i_frame_start ? '0 : r_col;
        c_inc = NCOL_W'(cur_c) + NCOL_W'(1);
        r_inc = NROW_W'(cur_r) + NROW_W'(1);
        cur_interior = (cur_r >= ROW_W'(2)) && (cur_c >= COL_W'(2))
                    && (NROW_W'(cur_r) < eff_rows) && (NCOL_W'(cur_c) < eff_cols);
        cur_last = (r_inc == eff_rows) && (c_inc == eff_cols);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.accept) begin
            if (c_inc >= eff_cols) begin
                r_col <= '0;
                r_row <= (r_inc >= eff_rows) ? '0 : ROW_W'(r_inc);
            end else begin
                r_col <= COL_W'(c_inc);
                r_row <= cur_r;
            end
        end
    end

    // Item held while it is worked on.
    logic [PIX_W-1:0] r_px;
    logic [ROW_W-1:0] r_cur_r;
    logic [COL_W-1:0] r_cur_c;
    logic             r_interior;
    logic             r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_px       <= i_pixel;
            r_cur_r    <= cur_r;
            r_cur_c    <= cur_c;
            r_interior <= cur_interior;
            r_last     <= cur_last;
        end
    end

    // Line stores: read on the input beat, written back in the next cycle.
    logic [PIX_W-1:0] mem_up [MAX_COLS];
    logic [PIX_W-1:0] mem_lo [MAX_COLS];
    logic [PIX_W-1:0] r_up_rd;
    logic [PIX_W-1:0] r_lo_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_up_rd <= mem_up[cur_c];
            r_lo_rd <= mem_lo[cur_c];
        end
        if (i_cmd.win_load) begin
            mem_up[r_cur_c] <= r_lo_rd;
            mem_lo[r_cur_c] <= r_px;
        end
    end

    // 3x3 window: first index is the row (top to bottom), second the column (oldest first).
    logic [PIX_W-1:0] r_win [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (i_cmd.win_load) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= r_up_rd;
            r_win[1][2] <= r_lo_rd;
            r_win[2][2] <= r_px;
        end
    end

    // Prewitt sums.
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [GRAD_W-1:0] r_gx;
    logic signed [GRAD_W-1:0] r_gy;

    always_comb begin
        gx = '0;
        gy = '0;
        for (int k = 0; k < 3; k++) begin
            gx = gx + $signed(GRAD_W'(r_win[k][2])) - $signed(GRAD_W'(r_win[k][0]));
            gy = gy + $signed(GRAD_W'(r_win[2][k])) - $signed(GRAD_W'(r_win[0][k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grad_load) begin
            r_gx <= gx;
            r_gy <= gy;
        end
    end

    logic signed [2*GRAD_W-1:0] prod_x;
    logic signed [2*GRAD_W-1:0] prod_y;
    logic [SQ_W-1:0]            r_sq_x;
    logic [SQ_W-1:0]            r_sq_y;

    assign prod_x = r_gx * r_gx;
    assign prod_y = r_gy * r_gy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_load) begin
            r_sq_x <= prod_x[SQ_W-1:0];
            r_sq_y <= prod_y[SQ_W-1:0];
        end
    end

    // Bit-pair square root, one result bit per cycle.
    logic [EN_W-1:0] r_rem;
    logic [EN_W-1:0] r_root;
    logic [EN_W-1:0] r_bit;
    logic [EN_W:0]   trial;
    logic            fits;

    assign trial = {1'b0, r_root} + {1'b0, r_bit};
    assign fits  = ({1'b0, r_rem} >= trial);

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_load) begin
            r_rem  <= EN_W'(r_sq_x) + EN_W'(r_sq_y);
            r_root <= '0;
            r_bit  <= EN_W'(1) << (EN_W - 1);
        end else if (i_cmd.sqrt_step) begin
            if (fits) begin
                r_rem  <= r_rem - trial[EN_W-1:0];
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // Output register.
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_magnitude  <= (r_root > EN_W'(MAG_MAX)) ? MAG_MAX : r_root[MAG_W-1:0];
            o_out_row    <= POS_W'(r_cur_r - ROW_W'(1));
            o_out_col    <= POS_W'(r_cur_c - COL_W'(1));
            o_frame_last <= r_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_sts.interior  = r_interior;
    assign o_sts.sqrt_last = r_bit[0];
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

endmodule

FILE: hw/rtl/prewitt_gradient_magnitude_unit.sv
// A taken pixel goes to the read state, then back to idle if it is on the border; an
// interior pixel passes the gradient, square, sum, square-root and done states, and the
// done state waits for a free output. Input is taken only in idle; the square root makes
// one result bit per cycle in a shared unit. A finished result waits in the output
// register while the next pixel is taken. Reset (synchronous) clears control, position
// and window and sets both sizes to 512; the line stores are not cleared.
module prewitt_gradient_magnitude_unit #(
    parameter int MAX_COLS = pgm_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = pgm_pkg::MAX_ROWS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pgm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pgm_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] pixel
    input  logic [pgm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // [0] frame_start
    input  logic [0:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [7:0] magnitude, [16:8] out_row, [25:17] out_col, [31:26] zero
    output logic [pgm_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output logic                               m_axis_tlast
);
    import pgm_pkg::*;

    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [MAG_W-1:0] magnitude;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;

    pgm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pgm_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pixel       (s_axis_tdata[PIX_W-1:0]),
        .i_frame_start (s_axis_tuser[0]),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_magnitude   (magnitude),
        .o_out_row     (out_row),
        .o_out_col     (out_col),
        .o_frame_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - MAG_W - 2 * POS_W)'(0), out_col, out_row, magnitude};

endmodule

FILE: hw/rtl/pgm_chk.sv
// Port-level checker for the Prewitt gradient magnitude unit, bound to the top level.
module pgm_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [pgm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // The line store write-back needs the cycle after an input beat.
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken in the cycle after a beat");

    // A new result only appears while a pixel is being worked on.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a pixel in work");

    // Results are interior pixels only, so row and column are never zero.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16:8] != 9'd0) && (m_axis_tdata[25:17] != 9'd0))
        else $error("result on a border position");

endmodule

bind prewitt_gradient_magnitude_unit pgm_chk u_pgm_chk (.*);
